// File: hdl/kst_pkg.sv
// Shared types and constants for the keyed slot table.
package kst_pkg;

  // Fixed widths of the transaction fields.
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned COUNT_W = 11;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 2'd0,
    CMD_FIND    = 2'd1,
    CMD_DELETE  = 2'd2,
    CMD_COMPACT = 2'd3
  } cmd_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND_LO,
    ST_FIND_HI,
    ST_FIND_CHK,
    ST_FIND_MID,
    ST_COMPACT
  } state_e;

endpackage

// File: hdl/kst_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module kst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; returns old data on a same-address write.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/keyed_slot_table_with_tombstones.sv
// Top level of the keyed slot table: command sequencer, search and compaction datapath.
//
// Usage: a command transaction (cmd_i, key_i, slot_i) is taken at a rising edge
// where start_i is high and busy_o is low. Exactly one result transaction follows:
// done_o is high for one cycle with ok_o, slot_out_o, id_out_o and count_out_o.
// The receiver cannot hold results off; each result is valid only in that cycle.
// Ids live in one synchronous RAM and live marks in a second one, both with a
// registered read port; the sequencer reads, decides and writes back.
// Steps from acceptance to done_o:
//   append, delete, find on an empty table: the result is registered at acceptance.
//   find: fetch both end points and check them; each halving round reads the
//     midpoint, fetches a new upper bound when one is needed and checks again.
//   compact: one slot read per cycle over the filled slots.
// busy_o stays low for append, delete and a find on an empty table; otherwise for find
// and compact it is high from the cycle after acceptance until done_o is shown, so a new
// command may be given in the cycle in which done_o is shown.
// Reset clears the fill count and the id counter; the RAMs are not cleared, as
// only slots below the fill count are ever read.
module keyed_slot_table_with_tombstones #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [kst_pkg::CMD_W-1:0]  cmd_i,
  input  logic [kst_pkg::ID_W-1:0]   key_i,
  input  logic [kst_pkg::SLOT_W-1:0] slot_i,
  output logic                       done_o,
  output logic                       ok_o,
  output logic [kst_pkg::SLOT_W-1:0] slot_out_o,
  output logic [kst_pkg::ID_W-1:0]   id_out_o,
  output logic [kst_pkg::COUNT_W-1:0] count_out_o
);

  import kst_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = CW + 16;

  state_e state_q, state_d;

  logic [CW-1:0]   fill_q, fill_d;
  logic [ID_W-1:0] next_id_q, next_id_d;
  logic [ID_W-1:0] key_q, key_d;

  logic [AW-1:0]   lo_q, lo_d, hi_q, hi_d, half_q, half_d;
  logic [ID_W-1:0] lo_id_q, lo_id_d, hi_id_q, hi_id_d;
  logic            lo_live_q, lo_live_d, hi_live_q, hi_live_d;

  logic [CW-1:0]   rd_i_q, rd_i_d, moved_q, moved_d;
  logic            pv_q, pv_d;

  logic               done_q, done_d, ok_q, ok_d;
  logic [SLOT_W-1:0]  slot_out_q, slot_out_d;
  logic [ID_W-1:0]    id_out_q, id_out_d;
  logic [COUNT_W-1:0] count_q, count_d;

  // RAM ports.
  logic            we_id, we_live;
  logic [AW-1:0]   waddr, raddr;
  logic [ID_W-1:0] wid, rid;
  logic [0:0]      wlive, rlive;

  // Shared conditions.
  logic            accept;
  logic [CW-1:0]   fill_m1;
  logic [XW-1:0]   fill_x, slot_x, moved_x, lo_x, hi_x, fill_p1_x;
  logic            full, empty, slot_ok;
  logic [AW-1:0]   half, mid, new_hi;
  logic            lo_hit, hi_hit, search_end, key_gt_mid;
  logic            cmp_issue, cmp_done;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign fill_m1   = fill_q - CW'(1);
  assign fill_x    = XW'(fill_q);
  assign fill_p1_x = fill_x + XW'(1);
  assign slot_x    = XW'(slot_i);
  assign moved_x   = XW'(moved_q);
  assign lo_x      = XW'(lo_q);
  assign hi_x      = XW'(hi_q);
  assign full      = (fill_q == CW'(CAPACITY));
  assign empty     = (fill_q == '0);
  assign slot_ok   = (slot_x < fill_x);

  // Search round conditions.
  assign half       = AW'((hi_q - lo_q) >> 1);
  assign lo_hit     = (lo_id_q == key_q);
  assign hi_hit     = (hi_id_q == key_q);
  assign search_end = lo_hit || hi_hit || (hi_q <= lo_q) || (half == '0);
  assign mid        = lo_q + half_q;
  assign new_hi     = hi_q - half_q;
  assign key_gt_mid = (key_q > rid);

  // Compaction stream conditions.
  assign cmp_issue = (rd_i_q < fill_q);
  assign cmp_done  = !cmp_issue && !pv_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_e'(cmd_i))
            CMD_FIND:    state_d = empty ? ST_IDLE : ST_FIND_LO;
            CMD_COMPACT: state_d = ST_COMPACT;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_FIND_LO:  state_d = ST_FIND_HI;
      ST_FIND_HI:  state_d = ST_FIND_CHK;
      ST_FIND_CHK: state_d = search_end ? ST_IDLE : ST_FIND_MID;
      ST_FIND_MID: begin
        state_d = (key_gt_mid || (new_hi == mid)) ? ST_FIND_CHK : ST_FIND_HI;
      end
      ST_COMPACT:  state_d = cmp_done ? ST_IDLE : ST_COMPACT;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath, RAM control and result.
  always_comb begin
    fill_d     = fill_q;
    next_id_d  = next_id_q;
    key_d      = key_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    half_d     = half_q;
    lo_id_d    = lo_id_q;
    hi_id_d    = hi_id_q;
    lo_live_d  = lo_live_q;
    hi_live_d  = hi_live_q;
    rd_i_d     = rd_i_q;
    moved_d    = moved_q;
    pv_d       = 1'b0;
    done_d     = 1'b0;
    ok_d       = ok_q;
    slot_out_d = slot_out_q;
    id_out_d   = id_out_q;
    count_d    = count_q;
    we_id      = 1'b0;
    we_live    = 1'b0;
    waddr      = '0;
    wid        = '0;
    wlive      = 1'b0;
    raddr      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d      = key_i;
          ok_d       = 1'b0;
          slot_out_d = '0;
          id_out_d   = '0;
          count_d    = fill_x[COUNT_W-1:0];
          unique case (cmd_e'(cmd_i))
            CMD_APPEND: begin
              done_d = 1'b1;
              if (!full) begin
                we_id      = 1'b1;
                we_live    = 1'b1;
                waddr      = fill_q[AW-1:0];
                wid        = next_id_q;
                wlive      = 1'b1;
                ok_d       = 1'b1;
                slot_out_d = fill_x[SLOT_W-1:0];
                id_out_d   = next_id_q;
                count_d    = fill_p1_x[COUNT_W-1:0];
                next_id_d  = next_id_q + ID_W'(1);
                fill_d     = fill_q + CW'(1);
              end
            end
            CMD_FIND: begin
              if (empty) begin
                done_d = 1'b1;
              end else begin
                raddr = '0;
                lo_d  = '0;
                hi_d  = fill_m1[AW-1:0];
              end
            end
            CMD_DELETE: begin
              done_d = 1'b1;
              if (slot_ok) begin
                we_live = 1'b1;
                waddr   = slot_x[AW-1:0];
                wlive   = 1'b0;
                ok_d    = 1'b1;
              end
            end
            CMD_COMPACT: begin
              rd_i_d  = '0;
              moved_d = '0;
            end
            default: ;
          endcase
        end
      end

      // Lower end point arrives; fetch the upper one.
      ST_FIND_LO: begin
        lo_id_d   = rid;
        lo_live_d = rlive[0];
        raddr     = hi_q;
      end

      ST_FIND_HI: begin
        hi_id_d   = rid;
        hi_live_d = rlive[0];
      end

      // Check both end points, then either finish or fetch the midpoint.
      ST_FIND_CHK: begin
        if (lo_hit) begin
          done_d     = 1'b1;
          ok_d       = lo_live_q;
          slot_out_d = lo_live_q ? lo_x[SLOT_W-1:0] : '0;
          id_out_d   = lo_live_q ? lo_id_q : '0;
        end else if (hi_hit) begin
          done_d     = 1'b1;
          ok_d       = hi_live_q;
          slot_out_d = hi_live_q ? hi_x[SLOT_W-1:0] : '0;
          id_out_d   = hi_live_q ? hi_id_q : '0;
        end else if (search_end) begin
          done_d = 1'b1;
        end else begin
          raddr  = lo_q + half;
          half_d = half;
        end
      end

      // Midpoint arrives; narrow the range.
      ST_FIND_MID: begin
        if (key_gt_mid) begin
          lo_d      = mid;
          lo_id_d   = rid;
          lo_live_d = rlive[0];
        end else begin
          hi_d = new_hi;
          if (new_hi == mid) begin
            hi_id_d   = rid;
            hi_live_d = rlive[0];
          end else begin
            raddr = new_hi;
          end
        end
      end

      // Stream reads over the filled slots and write live ones down in order.
      ST_COMPACT: begin
        pv_d = cmp_issue;
        if (cmp_issue) begin
          raddr  = rd_i_q[AW-1:0];
          rd_i_d = rd_i_q + CW'(1);
        end
        if (pv_q && rlive[0]) begin
          we_id   = 1'b1;
          we_live = 1'b1;
          waddr   = moved_q[AW-1:0];
          wid     = rid;
          wlive   = 1'b1;
          moved_d = moved_q + CW'(1);
        end
        if (cmp_done) begin
          fill_d  = moved_q;
          done_d  = 1'b1;
          ok_d    = 1'b1;
          count_d = moved_x[COUNT_W-1:0];
        end
      end

      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      next_id_q <= '0;
      done_q    <= 1'b0;
      pv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      next_id_q <= next_id_d;
      done_q    <= done_d;
      pv_q      <= pv_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    half_q     <= half_d;
    lo_id_q    <= lo_id_d;
    hi_id_q    <= hi_id_d;
    lo_live_q  <= lo_live_d;
    hi_live_q  <= hi_live_d;
    rd_i_q     <= rd_i_d;
    moved_q    <= moved_d;
    ok_q       <= ok_d;
    slot_out_q <= slot_out_d;
    id_out_q   <= id_out_d;
    count_q    <= count_d;
  end

  // Slot id store.
  kst_ram #(
    .WIDTH (ID_W),
    .DEPTH (CAPACITY)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (we_id),
    .waddr_i (waddr),
    .wdata_i (wid),
    .raddr_i (raddr),
    .rdata_o (rid)
  );

  // Live mark store.
  kst_ram #(
    .WIDTH (1),
    .DEPTH (CAPACITY)
  ) u_live_ram (
    .clk_i   (clk_i),
    .we_i    (we_live),
    .waddr_i (waddr),
    .wdata_i (wlive),
    .raddr_i (raddr),
    .rdata_o (rlive)
  );

  assign busy_o      = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign ok_o        = ok_q;
  assign slot_out_o  = slot_out_q;
  assign id_out_o    = id_out_q;
  assign count_out_o = count_q;

endmodule

// File: tb/sv/keyed_slot_table_monitor.sv
// Result monitor for the keyed slot table: tracks the table contents, predicts and compares.
module keyed_slot_table_monitor #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic [kst_pkg::CMD_W-1:0]   cmd_i,
  input  logic [kst_pkg::ID_W-1:0]    key_i,
  input  logic [kst_pkg::SLOT_W-1:0]  slot_i,
  input  logic                        done_i,
  input  logic                        ok_i,
  input  logic [kst_pkg::SLOT_W-1:0]  slot_out_i,
  input  logic [kst_pkg::ID_W-1:0]    id_out_i,
  input  logic [kst_pkg::COUNT_W-1:0] count_out_i,
  output int unsigned                 mismatch_count_o,
  output int unsigned                 results_owed_o
);

  import kst_pkg::*;

  // One result transaction as the block should report it.
  typedef struct packed {
    logic               ok;
    logic [SLOT_W-1:0]  slot;
    logic [ID_W-1:0]    id;
    logic [COUNT_W-1:0] count;
  } table_result_t;

  // Shadow copy of the table.
  bit [ID_W-1:0] table_ids [CAPACITY];
  bit            table_live [CAPACITY];
  int unsigned   table_fill;
  bit [ID_W-1:0] table_next_id;

  table_result_t owed_results [$];
  table_result_t oldest_owed;
  int unsigned   mismatches;

  // Binary search over the filled slots, testing both ends of the range each round.
  // A key that matches a dead slot counts as a miss.
  function automatic bit search_live_id(input logic [ID_W-1:0] key, output int unsigned found);
    int unsigned lo;
    int unsigned hi;
    int unsigned half;
    int unsigned mid;
    int unsigned hit;
    bit matched;
    found = 0;
    hit = 0;
    matched = 1'b0;
    if (table_fill == 0 || table_fill > CAPACITY) return 1'b0;
    lo = 0;
    hi = table_fill - 1;
    while (!matched) begin
      if (table_ids[lo] == key) begin
        hit = lo;
        matched = 1'b1;
      end else if (table_ids[hi] == key) begin
        hit = hi;
        matched = 1'b1;
      end else begin
        if (hi <= lo) return 1'b0;
        half = (hi - lo) / 2;
        if (half == 0) return 1'b0;
        mid = lo + half;
        if (key > table_ids[mid]) begin
          lo = mid;
        end else begin
          hi = hi - half;
        end
      end
    end
    if (!table_live[hit]) return 1'b0;
    found = hit;
    return 1'b1;
  endfunction

  // Applies one command to the shadow table and returns the result it must produce.
  function automatic table_result_t apply_to_table(input cmd_e cmd, input logic [ID_W-1:0] key,
                                                   input logic [SLOT_W-1:0] slot);
    table_result_t res;
    int unsigned where;
    int unsigned moved;
    res = '0;
    case (cmd)
      CMD_APPEND: begin
        if (table_fill < CAPACITY) begin
          table_ids[table_fill] = table_next_id;
          table_live[table_fill] = 1'b1;
          res.ok = 1'b1;
          res.slot = SLOT_W'(table_fill);
          res.id = table_next_id;
          table_next_id = table_next_id + 1;
          table_fill = table_fill + 1;
        end
      end
      CMD_FIND: begin
        if (search_live_id(key, where)) begin
          res.ok = 1'b1;
          res.slot = SLOT_W'(where);
          res.id = table_ids[where];
        end
      end
      CMD_DELETE: begin
        if (slot < table_fill) begin
          table_live[slot] = 1'b0;
          res.ok = 1'b1;
        end
      end
      default: begin
        // Live slots slide down in order and keep their ids.
        moved = 0;
        for (int unsigned i = 0; i < table_fill && i < CAPACITY; i++) begin
          if (table_live[i]) begin
            table_ids[moved] = table_ids[i];
            table_live[moved] = 1'b1;
            moved++;
          end
        end
        table_fill = moved;
        res.ok = 1'b1;
      end
    endcase
    res.count = COUNT_W'(table_fill);
    return res;
  endfunction

  function automatic void compare_field(input string name, input logic [ID_W-1:0] want,
                                        input logic [ID_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Check each result against the oldest outstanding command, then log any new command.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_fill = 0;
      table_next_id = '0;
      owed_results.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      results_owed_o <= 0;
    end else begin
      if (done_i) begin
        if (owed_results.size() == 0) begin
          $error("result transaction with no command outstanding");
          mismatches++;
        end else begin
          oldest_owed = owed_results.pop_front();
          compare_field("ok", ID_W'(oldest_owed.ok), ID_W'(ok_i));
          compare_field("slot_out", ID_W'(oldest_owed.slot), ID_W'(slot_out_i));
          compare_field("id_out", oldest_owed.id, id_out_i);
          compare_field("count_out", ID_W'(oldest_owed.count), ID_W'(count_out_i));
        end
      end
      if (start_i && !busy_i) begin
        owed_results.push_back(apply_to_table(cmd_e'(cmd_i), key_i, slot_i));
      end
      mismatch_count_o <= mismatches;
      results_owed_o <= owed_results.size();
    end
  end

endmodule

// File: tb/sv/keyed_slot_table_with_tombstones_tb.sv
// Testbench top for the keyed slot table: command stimulus, watchdog and verdict.
module keyed_slot_table_with_tombstones_tb;
  import kst_pkg::*;

  localparam int unsigned CAPACITY       = 1024;
  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = CAPACITY + 8;
  localparam int unsigned PHASE_ITEMS    = 40;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  cmd_e               cmd;
  logic [ID_W-1:0]    key;
  logic [SLOT_W-1:0]  slot;
  logic               done;
  logic               ok;
  logic [SLOT_W-1:0]  slot_out;
  logic [ID_W-1:0]    id_out;
  logic [COUNT_W-1:0] count_out;

  int unsigned mismatch_count;
  int unsigned results_owed;
  int unsigned appends_sent;
  int unsigned fill_seen;
  int unsigned quiet_cycles;

  always #2 clk = ~clk;

  keyed_slot_table_with_tombstones #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_o     (busy),
    .cmd_i      (cmd),
    .key_i      (key),
    .slot_i     (slot),
    .done_o     (done),
    .ok_o       (ok),
    .slot_out_o (slot_out),
    .id_out_o   (id_out),
    .count_out_o(count_out)
  );

  keyed_slot_table_monitor #(
    .CAPACITY(CAPACITY)
  ) table_monitor (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_i          (busy),
    .cmd_i           (cmd),
    .key_i           (key),
    .slot_i          (slot),
    .done_i          (done),
    .ok_i            (ok),
    .slot_out_i      (slot_out),
    .id_out_i        (id_out),
    .count_out_i     (count_out),
    .mismatch_count_o(mismatch_count),
    .results_owed_o  (results_owed)
  );

  // Fill count as last reported, used to aim deletes at filled slots.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      fill_seen <= 0;
    end else if (done) begin
      fill_seen <= count_out;
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Present one command and hold it until the block takes it.
  task automatic issue(input cmd_e op, input logic [ID_W-1:0] k, input logic [SLOT_W-1:0] s);
    cmd <= op;
    key <= k;
    slot <= s;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (op == CMD_APPEND) appends_sent++;
  endtask

  // Sender gaps: each cycle idles with the given percent chance, with junk on the fields.
  task automatic hold_off(input int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      cmd <= cmd_e'($urandom_range(3));
      key <= $urandom;
      slot <= SLOT_W'($urandom);
      @(posedge clk);
    end
  endtask

  // Random command; find keys are mostly near the ids handed out so far, plus boundaries and arbitrary keys.
  task automatic random_command();
    int unsigned pick;
    int unsigned sel;
    logic [ID_W-1:0] probe;
    logic [SLOT_W-1:0] target;
    pick = $urandom_range(99);
    sel = $urandom_range(99);
    if (pick < 35) begin
      issue(CMD_APPEND, $urandom, SLOT_W'($urandom));
    end else if (pick < 75) begin
      if (sel < 75) begin
        probe = $urandom_range(appends_sent + 1);
      end else if (sel < 85) begin
        case ($urandom_range(3))
          0: probe = '0;
          1: probe = appends_sent - 1;
          2: probe = appends_sent;
          default: probe = '1;
        endcase
      end else begin
        probe = $urandom;
      end
      issue(CMD_FIND, probe, SLOT_W'($urandom));
    end else if (pick < 94) begin
      if (sel < 70) begin
        target = SLOT_W'($urandom_range(fill_seen + 1));
      end else begin
        target = SLOT_W'($urandom);
      end
      issue(CMD_DELETE, $urandom, target);
    end else begin
      issue(CMD_COMPACT, $urandom, SLOT_W'($urandom));
    end
  endtask

  task automatic run_random(input int unsigned items, input int unsigned idle_pct);
    repeat (items) begin
      hold_off(idle_pct);
      random_command();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cmd = CMD_APPEND;
    key = '0;
    slot = '0;
    appends_sent = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: find misses, delete is out of range, compact keeps zero.
    issue(CMD_FIND, '0, '0);
    issue(CMD_DELETE, '0, '0);
    issue(CMD_COMPACT, '1, '1);
    repeat (5) issue(CMD_APPEND, '1, '1);
    // Hits on the lower end, the upper end and interior slots.
    issue(CMD_FIND, 32'd0, '0);
    issue(CMD_FIND, 32'd4, '0);
    issue(CMD_FIND, 32'd2, '0);
    issue(CMD_FIND, 32'd1, '0);
    // Key on a dead slot, a repeated delete and deletes beyond the fill count.
    issue(CMD_DELETE, '0, 10'd2);
    issue(CMD_FIND, 32'd2, '0);
    issue(CMD_DELETE, '0, 10'd2);
    issue(CMD_FIND, '1, '0);
    issue(CMD_DELETE, '0, '1);
    issue(CMD_DELETE, '0, 10'd5);
    // Compaction drops the dead slot and moves the rest down with their ids.
    issue(CMD_COMPACT, '0, '0);
    issue(CMD_FIND, 32'd3, '0);
    issue(CMD_FIND, 32'd2, '0);
    issue(CMD_APPEND, '0, '0);
    issue(CMD_FIND, 32'd5, '0);

    run_random(PHASE_ITEMS, 11);
    run_random(PHASE_ITEMS, 56);
    run_random(PHASE_ITEMS, 0);

    // Full table: appends past capacity fail, then search, delete and compact at full size.
    issue(CMD_COMPACT, '0, '0);
    while (fill_seen < CAPACITY) issue(CMD_APPEND, $urandom, SLOT_W'($urandom));
    repeat (4) issue(CMD_APPEND, $urandom, SLOT_W'($urandom));
    repeat (30) issue(CMD_FIND, $urandom_range(appends_sent + 1), '0);
    issue(CMD_FIND, appends_sent - 5, '0);
    issue(CMD_DELETE, '0, '1);
    issue(CMD_DELETE, '0, '0);
    repeat (10) random_command();
    issue(CMD_COMPACT, '0, '0);
    repeat (10) random_command();

    start <= 1'b0;
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
